[sv/lpnsc_pkg.sv]
// Shared types and constants for the length-prefixed unit to start-code converter.
// Used by the parser, the burst stage and the top level.
package lpnsc_pkg;

  // Start code sent ahead of every unit, first byte first
  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};
  localparam logic [1:0] START_CODE_LAST = 2'd3;

  // Length prefix size register: reset value and legal range
  localparam logic [2:0] LEN_BYTES_RESET = 3'd4;
  localparam logic [2:0] LEN_BYTES_MIN   = 3'd1;
  localparam logic [2:0] LEN_BYTES_MAX   = 3'd4;

  // What one accepted input beat turns into
  typedef enum logic {
    KIND_SINGLE = 1'b0,   // one result: payload byte or status only
    KIND_START  = 1'b1    // four results: the start code
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;        // payload byte, zero on a status-only result
    logic       data_valid;  // single result carries a byte
    logic       trunc;       // box ended early; shown on the last result
  } desc_t;

endpackage

[sv/lpnsc_stream_if.sv]
// Valid/ready stream interfaces for the converter: box bytes in, stream bytes out.
// Depends on nothing but the handshake convention (beat on valid && ready).
interface lpnsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       box_end;

  modport source (output valid, output data_byte, output box_end, input ready);
  modport sink   (input valid, input data_byte, input box_end, output ready);
endinterface

interface lpnsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       starts_unit;
  logic       truncated;
  logic       run_last;

  modport source (output valid, output out_byte, output byte_valid, output starts_unit,
                  output truncated, output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input starts_unit,
                  input truncated, input run_last, output ready);
endinterface

[sv/lpnsc_parser.sv]
// Prefix/payload parser: holds the unit state and the prefix size register and
// turns each input beat into a result descriptor, flagged by has_result. Uses lpnsc_pkg.
module lpnsc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              box_end,
  output logic              has_result,
  output lpnsc_pkg::desc_t  desc
);

  logic [2:0]  len_bytes;
  logic        in_payload;
  logic [1:0]  seen;
  logic [31:0] left;

  logic        in_payload_next;
  logic [1:0]  seen_next;
  logic [31:0] left_next;

  logic [2:0]  plen;
  logic [2:0]  seen_inc;
  logic [31:0] acc;
  logic [31:0] left_dec;

  // Effective prefix size: zero acts as one, above four acts as four
  always_comb begin
    if (len_bytes < lpnsc_pkg::LEN_BYTES_MIN) begin
      plen = lpnsc_pkg::LEN_BYTES_MIN;
    end else if (len_bytes > lpnsc_pkg::LEN_BYTES_MAX) begin
      plen = lpnsc_pkg::LEN_BYTES_MAX;
    end else begin
      plen = len_bytes;
    end
  end

  assign seen_inc = {1'b0, seen} + 3'd1;
  assign acc      = (seen == 2'd0) ? {24'd0, data_byte} : {left[23:0], data_byte};
  assign left_dec = left - 32'd1;

  // Next state and descriptor for the beat on the input
  always_comb begin
    in_payload_next = in_payload;
    seen_next       = seen;
    left_next       = left;
    has_result      = 1'b0;
    desc.kind       = lpnsc_pkg::KIND_SINGLE;
    desc.data       = 8'd0;
    desc.data_valid = 1'b0;
    desc.trunc      = 1'b0;

    if (in_payload) begin
      // payload byte passes through
      left_next       = left_dec;
      in_payload_next = (left_dec != 32'd0);
      has_result      = 1'b1;
      desc.data       = data_byte;
      desc.data_valid = 1'b1;
      desc.trunc      = box_end && (left_dec != 32'd0);
    end else if (seen_inc >= plen) begin
      // prefix complete: start code follows
      left_next       = acc;
      seen_next       = 2'd0;
      in_payload_next = (acc != 32'd0);
      has_result      = 1'b1;
      desc.kind       = lpnsc_pkg::KIND_START;
      desc.trunc      = box_end && (acc != 32'd0);
    end else begin
      // more prefix bytes to come
      left_next  = acc;
      seen_next  = seen_inc[1:0];
      has_result = box_end;
      desc.trunc = 1'b1;
    end

    // last byte of the box returns everything to idle
    if (box_end) begin
      in_payload_next = 1'b0;
      seen_next       = 2'd0;
      left_next       = 32'd0;
    end
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len_bytes  <= lpnsc_pkg::LEN_BYTES_RESET;
      in_payload <= 1'b0;
      seen       <= 2'd0;
      left       <= 32'd0;
    end else begin
      if (cfg_we) begin
        len_bytes <= cfg_wdata;
      end
      if (accept) begin
        in_payload <= in_payload_next;
        seen       <= seen_next;
        left       <= left_next;
      end
    end
  end

  // A prefix in progress never reaches the largest prefix size
  assert property (@(posedge clk) disable iff (rst)
    !in_payload |-> ({1'b0, seen} < lpnsc_pkg::LEN_BYTES_MAX))
    else $error("prefix byte count ran past the prefix size");

  // Payload mode always has bytes left to pass
  assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (left != 32'd0))
    else $error("payload mode with no bytes left");

  // Box end always leaves the parser idle
  assert property (@(posedge clk) disable iff (rst)
    accept && box_end |=> !in_payload && (seen == 2'd0) && (left == 32'd0))
    else $error("state not cleared after box end");

endmodule

[sv/lpnsc_burst.sv]
// Output side: a one-entry descriptor buffer and the result register that
// expands a descriptor into one beat or the four start-code beats. Uses lpnsc_pkg.
module lpnsc_burst (
  input  logic              clk,
  input  logic              rst,
  input  logic              desc_valid,
  input  lpnsc_pkg::desc_t  desc,
  output logic              desc_ready,
  lpnsc_out_if.source       stream
);

  logic             a_valid;
  lpnsc_pkg::desc_t a_desc;
  logic             b_valid;
  lpnsc_pkg::desc_t b_desc;
  logic [1:0]       b_idx;

  logic b_last;
  logic b_done;
  logic move;

  assign b_last     = (b_desc.kind == lpnsc_pkg::KIND_SINGLE) ||
                      (b_idx == lpnsc_pkg::START_CODE_LAST);
  assign b_done     = b_valid && stream.ready && b_last;
  assign move       = a_valid && (!b_valid || b_done);
  assign desc_ready = !a_valid || move;

  // Result fields straight from the result register
  always_comb begin
    stream.valid = b_valid;
    stream.run_last = b_last;
    if (b_desc.kind == lpnsc_pkg::KIND_START) begin
      stream.out_byte    = lpnsc_pkg::START_CODE[b_idx];
      stream.byte_valid  = 1'b1;
      stream.starts_unit = (b_idx == 2'd0);
      stream.truncated   = b_desc.trunc && (b_idx == lpnsc_pkg::START_CODE_LAST);
    end else begin
      stream.out_byte    = b_desc.data;
      stream.byte_valid  = b_desc.data_valid;
      stream.starts_unit = 1'b0;
      stream.truncated   = b_desc.trunc;
    end
  end

  // Buffer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      b_idx   <= 2'd0;
    end else begin
      if (desc_valid && desc_ready) begin
        a_valid <= 1'b1;
      end else if (move) begin
        a_valid <= 1'b0;
      end

      if (move) begin
        b_valid <= 1'b1;
        b_idx   <= 2'd0;
      end else if (b_done) begin
        b_valid <= 1'b0;
        b_idx   <= 2'd0;
      end else if (b_valid && stream.ready) begin
        b_idx <= b_idx + 2'd1;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (desc_valid && desc_ready) begin
      a_desc <= desc;
    end
    if (move) begin
      b_desc <= a_desc;
    end
  end

  // A single result never advances the beat index
  assert property (@(posedge clk) disable iff (rst)
    b_valid && (b_desc.kind == lpnsc_pkg::KIND_SINGLE) |-> (b_idx == 2'd0))
    else $error("beat index moved on a single result");

  // Truncation is only flagged on the last beat of an input byte
  assert property (@(posedge clk) disable iff (rst)
    stream.valid && stream.truncated |-> stream.run_last)
    else $error("truncated flag away from the last beat");

  // A waiting descriptor holds until it moves on
  assert property (@(posedge clk) disable iff (rst)
    a_valid && !move |=> a_valid && $stable(a_desc))
    else $error("buffered descriptor lost or changed");

  // A stalled burst keeps its place
  assert property (@(posedge clk) disable iff (rst)
    b_valid && !stream.ready |=> b_valid && $stable(b_idx))
    else $error("burst advanced while stalled");

endmodule

[sv/length_prefixed_nal_to_start_code_unit.sv]
// Top level of the length-prefixed unit to start-code converter.
// Depends on lpnsc_pkg, lpnsc_stream_if, lpnsc_parser and lpnsc_burst.
//
// Takes the media-data box payload one byte per beat on box and sends the
// start-code stream on stream. Each unit's big-endian length prefix
// (cfg_wdata bytes, 1 to 4, reset 4; 0 acts as 1, above 4 as 4) is swallowed
// and replaced by 00 00 00 01, the first byte flagged starts_unit; payload
// bytes pass through one per beat. A box that ends inside a prefix gives a
// status-only beat with truncated set; one that ends with payload still owed
// sets truncated on that byte's last beat. Payload and prefix bytes are taken
// one per cycle while the descriptor buffer can take them; a completed prefix
// is sent as the four start-code beats from the single output register. A
// two-entry path (one descriptor buffer plus the result register) lets the next
// byte in while a result waits. Write the configuration only while the block is
// idle.
module length_prefixed_nal_to_start_code_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  lpnsc_in_if.sink    box,
  lpnsc_out_if.source stream
);

  logic             accept;
  logic             has_result;
  logic             desc_ready;
  lpnsc_pkg::desc_t desc;

  // Input handshake
  assign box.ready = desc_ready;
  assign accept    = box.valid && desc_ready;

  lpnsc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .data_byte  (box.data_byte),
    .box_end    (box.box_end),
    .has_result (has_result),
    .desc       (desc)
  );

  lpnsc_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (accept && has_result),
    .desc       (desc),
    .desc_ready (desc_ready),
    .stream     (stream)
  );

endmodule

[sim/tb_top.sv]
// Testbench for length_prefixed_nal_to_start_code_unit: random boxes of length-prefixed
// units in, start-code stream out, checked beat by beat against an in-bench predictor.
// Depends on lpnsc_pkg, lpnsc_stream_if and the converter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_TICKS = 10;
  localparam int unsigned PHASE_BEATS  = 4;
  localparam int unsigned NO_END       = 32'hFFFF_FFFF;

  // One box byte waiting to be sent, with the idle gap that follows it
  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
  } box_item_t;

  // One stream beat as the converter should send it
  typedef struct {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       starts_unit;
    logic       truncated;
    logic       run_last;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  lpnsc_in_if  box_if ();
  lpnsc_out_if stream_if ();

  length_prefixed_nal_to_start_code_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .box       (box_if),
    .stream    (stream_if)
  );

  box_item_t   box_bytes[$];
  out_beat_t   stream_beats[$];
  int unsigned err_count = 0;
  int unsigned queued = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // Converter state as predicted, plus the prefix size register
  logic [2:0]  len_cfg = lpnsc_pkg::LEN_BYTES_RESET;
  logic        in_unit = 1'b0;
  logic [1:0]  prefix_seen = 2'd0;
  logic [31:0] bytes_owed = 32'd0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_err(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Out-of-range register values clamp to the legal prefix sizes
  function automatic int unsigned prefix_bytes(input logic [2:0] v);
    if (v < lpnsc_pkg::LEN_BYTES_MIN) return lpnsc_pkg::LEN_BYTES_MIN;
    if (v > lpnsc_pkg::LEN_BYTES_MAX) return lpnsc_pkg::LEN_BYTES_MAX;
    return v;
  endfunction

  task automatic push_beat(input logic [7:0] b, input logic v, input logic first,
                           input logic cut, input logic last);
    out_beat_t beat;
    beat.out_byte    = b;
    beat.byte_valid  = v;
    beat.starts_unit = first;
    beat.truncated   = cut;
    beat.run_last    = last;
    stream_beats.push_back(beat);
  endtask

  // Expected stream beats for one accepted box byte
  task automatic predict_beats(input logic [7:0] d, input logic last);
    logic [2:0] seen;
    logic       cut;
    int         i;
    if (in_unit) begin
      bytes_owed = bytes_owed - 32'd1;
      if (bytes_owed == 32'd0) in_unit = 1'b0;
      push_beat(d, 1'b1, 1'b0, last && (bytes_owed != 32'd0), 1'b1);
    end else begin
      bytes_owed = (prefix_seen == 2'd0) ? {24'd0, d} : {bytes_owed[23:0], d};
      seen = {1'b0, prefix_seen} + 3'd1;
      if (seen >= prefix_bytes(len_cfg)) begin
        // prefix complete: start code, truncated only on its last byte
        cut = last && (bytes_owed != 32'd0);
        prefix_seen = 2'd0;
        in_unit = (bytes_owed != 32'd0);
        for (i = 0; i < 4; i++) begin
          push_beat(lpnsc_pkg::START_CODE[i], 1'b1, i == 0,
                    (i == lpnsc_pkg::START_CODE_LAST) ? cut : 1'b0,
                    i == lpnsc_pkg::START_CODE_LAST);
        end
      end else begin
        prefix_seen = seen[1:0];
        if (last) push_beat(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
      end
    end
    if (last) begin
      in_unit = 1'b0;
      prefix_seen = 2'd0;
      bytes_owed = 32'd0;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_err($sformatf("%s mismatch: got %0h, expected %0h",
                                           name, got, want));
  endtask

  // Box byte driver
  always @(posedge clk) begin : drive
    box_item_t nxt;
    if (rst) begin
      box_if.valid     <= 1'b0;
      box_if.data_byte <= 8'h00;
      box_if.box_end   <= 1'b0;
      gap_left <= 0;
      in_unit = 1'b0;
      prefix_seen = 2'd0;
      bytes_owed = 32'd0;
    end else begin
      if (box_if.valid && box_if.ready) predict_beats(box_if.data_byte, box_if.box_end);
      if (box_if.valid && !box_if.ready) begin
        // beat still offered, hold it
      end else if (gap_left != 0) begin
        box_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (box_bytes.size() != 0) begin
        nxt = box_bytes.pop_front();
        box_if.valid     <= 1'b1;
        box_if.data_byte <= nxt.data;
        box_if.box_end   <= nxt.last;
        gap_left         <= nxt.gap;
      end else begin
        box_if.valid <= 1'b0;
      end
    end
  end

  // Stream monitor and backpressure
  always @(posedge clk) begin : watch
    out_beat_t   want;
    int unsigned hold;
    if (rst) begin
      stream_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (stream_if.valid && stream_if.ready) begin
        if (stream_beats.size() == 0) begin
          report_err($sformatf("stream beat with none expected: out_byte %0h",
                               stream_if.out_byte));
        end else begin
          want = stream_beats.pop_front();
          check_field("out_byte", stream_if.out_byte, want.out_byte);
          check_field("byte_valid", 8'(stream_if.byte_valid), 8'(want.byte_valid));
          check_field("starts_unit", 8'(stream_if.starts_unit), 8'(want.starts_unit));
          check_field("truncated", 8'(stream_if.truncated), 8'(want.truncated));
          check_field("run_last", 8'(stream_if.run_last), 8'(want.run_last));
        end
        if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
        hold = out_calm ? 0 : $urandom_range(0, 11);
      end
      if (hold != 0) begin
        stream_if.ready <= 1'b0;
        stall_left <= hold - 1;
      end else begin
        stream_if.ready <= 1'b1;
        stall_left <= 0;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] d, input logic last);
    box_item_t item;
    if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
    item.data = d;
    item.last = last;
    item.gap  = in_calm ? 0 : $urandom_range(0, 11);
    box_bytes.push_back(item);
    queued++;
  endtask

  // Big-endian length prefix; end_at marks the byte that closes the box
  task automatic add_prefix(input int unsigned len, input int unsigned nb,
                            input int unsigned end_at);
    int unsigned k;
    for (k = 0; k < nb; k++) add_byte(8'(len >> (8 * (nb - 1 - k))), k == end_at);
  endtask

  task automatic add_payload(input int unsigned len, input int unsigned end_at);
    int unsigned k;
    for (k = 0; k < len; k++) add_byte(8'($urandom_range(0, 255)), k == end_at);
  endtask

  // Mostly short units, zero length fairly often
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return 0;
    if (r < 16) return $urandom_range(1, 6);
    return $urandom_range(7, 24);
  endfunction

  // One box: well-formed most of the time, otherwise cut short or noise
  task automatic add_box(input int unsigned nb);
    int unsigned units, shape, len, k, u;
    units = $urandom_range(1, 3);
    shape = $urandom_range(0, 9);
    if (shape == 9) begin
      len = $urandom_range(1, 12);
      for (k = 0; k < len; k++) begin
        add_byte(8'($urandom_range(0, 255)), (k == len - 1) || ($urandom_range(0, 7) == 0));
      end
    end else begin
      for (u = 0; u < units; u++) begin
        len = pick_len();
        if (u != units - 1) begin
          add_prefix(len, nb, NO_END);
          add_payload(len, NO_END);
        end else if (shape == 6 && nb > 1) begin
          // box ends inside the prefix
          add_prefix(len, nb, $urandom_range(0, nb - 2));
        end else if (shape == 6 || shape == 7) begin
          // box ends on the byte that completes a nonzero prefix
          add_prefix((len == 0) ? 1 : len, nb, nb - 1);
        end else if (shape == 8) begin
          // box ends with payload still owed
          if (len < 2) len = len + 2;
          add_prefix(len, nb, NO_END);
          add_payload(len, $urandom_range(0, len - 2));
        end else if (len == 0) begin
          add_prefix(0, nb, nb - 1);
        end else begin
          add_prefix(len, nb, NO_END);
          add_payload(len, len - 1);
        end
      end
    end
  endtask

  task automatic write_len_cfg(input logic [2:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    len_cfg = v;
  endtask

  // Wait until all beats are in and out, then let the pipeline settle
  task automatic drain();
    while (box_bytes.size() != 0 || box_if.valid || stream_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  initial begin
    logic [2:0]  cfg_plan [10];
    int unsigned p, phase_start;
    cfg_plan = '{3'd1, 3'd4, 3'd0, 3'd3, 3'd7, 3'd2, 3'd5, 3'd6, 3'd4, 3'd1};
    cfg_we           = 1'b0;
    cfg_wdata        = 3'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Zero-length unit: start code only
    add_prefix(0, 4, NO_END);
    // One-byte unit closing the box normally
    add_prefix(1, 4, NO_END);
    add_byte(8'hFF, 1'b1);
    // Largest length, box ends with payload owed
    add_prefix(32'hFFFF_FFFF, 4, NO_END);
    add_byte(8'h00, 1'b1);
    // Box ends inside the prefix
    add_prefix(0, 4, 1);
    // Box ends on completing a nonzero prefix
    add_prefix(3, 4, 3);
    drain();

    // Prefix size changed with two prefix bytes already taken
    add_prefix(0, 2, NO_END);
    drain();
    write_len_cfg(3'd2);
    add_byte(8'h02, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b1);
    drain();

    // Random boxes under each register setting
    for (p = 0; p < 10; p++) begin
      write_len_cfg(cfg_plan[p]);
      phase_start = queued;
      while (queued - phase_start < PHASE_BEATS) add_box(prefix_bytes(len_cfg));
      drain();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
